FILE: src/tdpg_pkg.sv
// Package for the trial-division prime generator.
// Sizes, transaction layouts and the remainder unit's status struct.
// No dependencies.
package tdpg_pkg;

   localparam int TABLE_DEPTH   = 4096;
   localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS    = ADDR_BITS + 1;
   localparam int VALUE_BITS    = 15;
   localparam int NEXT_BITS     = VALUE_BITS + 1;
   localparam int SQ_BITS       = 2 * VALUE_BITS;
   localparam int STEP_BITS     = $clog2(VALUE_BITS + 1);

   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_FIELD_BITS = VALUE_BITS + 1 + COUNT_BITS + 1;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [VALUE_BITS-1:0] LIMIT_RESET = {VALUE_BITS{1'b1}};
   localparam logic [NEXT_BITS-1:0]  FIRST_CAND  = NEXT_BITS'(3);
   localparam logic [VALUE_BITS-1:0] FIRST_PRIME = VALUE_BITS'(2);

   typedef struct packed {
      logic done;   // one-cycle pulse, remainder ready
      logic zero;   // remainder is zero
   } mod_result_type;

endpackage

FILE: src/tdpg_ram.sv
// Prime table storage: one write port, one read port, registered read data.
// Depends on tdpg_pkg.
module tdpg_ram (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [tdpg_pkg::ADDR_BITS-1:0]      wr_addr,
   input  logic [tdpg_pkg::VALUE_BITS-1:0]     wr_data,
   input  logic [tdpg_pkg::ADDR_BITS-1:0]      rd_addr,
   output logic [tdpg_pkg::VALUE_BITS-1:0]     rd_data
);

   logic [tdpg_pkg::VALUE_BITS-1:0] mem [tdpg_pkg::TABLE_DEPTH];
   logic [tdpg_pkg::VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/tdpg_mod_unit.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on tdpg_pkg.
module tdpg_mod_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tdpg_pkg::VALUE_BITS-1:0]     dividend,
   input  logic [tdpg_pkg::VALUE_BITS-1:0]     divisor,
   output tdpg_pkg::mod_result_type            result
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [tdpg_pkg::STEP_BITS-1:0]      cnt_ff;
   logic [tdpg_pkg::VALUE_BITS-1:0]     rem_ff;
   logic [tdpg_pkg::VALUE_BITS-1:0]     dvd_ff;
   logic [tdpg_pkg::VALUE_BITS-1:0]     div_ff;

   logic [tdpg_pkg::VALUE_BITS:0]       trial;
   logic [tdpg_pkg::VALUE_BITS:0]       diff;
   logic [tdpg_pkg::VALUE_BITS-1:0]     rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[tdpg_pkg::VALUE_BITS-1]};
      diff   = trial - {1'b0, div_ff};
      rem_in = (trial >= {1'b0, div_ff}) ? diff[tdpg_pkg::VALUE_BITS-1:0]
                                         : trial[tdpg_pkg::VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == tdpg_pkg::STEP_BITS'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         cnt_ff <= tdpg_pkg::STEP_BITS'(tdpg_pkg::VALUE_BITS);
         rem_ff <= '0;
         dvd_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - tdpg_pkg::STEP_BITS'(1);
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[tdpg_pkg::VALUE_BITS-2:0], 1'b0};
      end
   end

   assign result.done = done_ff;
   assign result.zero = (rem_ff == '0);

endmodule

FILE: src/trial_division_prime_generator.sv
// Top level of the trial-division prime generator.
// Depends on tdpg_pkg, tdpg_ram and tdpg_mod_unit.
//
// Usage:
//  - req_ channel: one transaction per tick; req_tdata[0] = restart. A restart
//    tick clears the table back to the single prime 2 and the candidate to 3.
//  - rsp_ channel: one transaction per tick, in order, with the odd candidate
//    tested, its prime flag, the running table count and the done flag.
//  - csr_ port: writes upper_limit (15 bits); write only while the block is idle.
//  - Processing: a restart or done tick goes straight to its result. A tested
//    candidate walks the stored primes in order; each prime that needs a
//    remainder passes through table read, load, squaring, compare, bit-serial
//    remainder and its done pulse. A candidate ends at the square test, at a
//    zero remainder or after the last stored prime. The remainder unit sets
//    the rate.
//  - One tick is worked on at a time; req_tready is high only when idle, and the
//    next tick is taken at the earliest in the cycle after its result is loaded.
//    The result sits in an output register, so a new tick is taken while the
//    last result waits; if the receiver still stalls when the next result is
//    ready, the block holds it internally (req_tready low) until rsp_tready.
//  - Reset (synchronous) restores the table to {2}, the candidate to 3 and the
//    limit to 32767. Table entry 0 is a constant, so no clearing pass is needed.
//  - New primes are written at the end of a tick; the next tick reads the table
//    only after that write has landed, so no forwarding is required.
module trial_division_prime_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   // restart (bit 0)
   input  logic [tdpg_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // candidate_value [14:0], is_prime [15], prime_count [28:16], done_res [29]
   output logic [tdpg_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_wr_en,
   input  logic [tdpg_pkg::VALUE_BITS-1:0]       csr_wr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_LOAD,
      S_SQUARE,
      S_CHECK,
      S_DIVIDE,
      S_FINISH
   } state_type;

   state_type                             state_ff;
   logic [tdpg_pkg::VALUE_BITS-1:0]       limit_ff;
   logic [tdpg_pkg::NEXT_BITS-1:0]        next_cand_ff;
   logic [tdpg_pkg::COUNT_BITS-1:0]       count_ff;
   logic [tdpg_pkg::COUNT_BITS-1:0]       idx_ff;
   logic [tdpg_pkg::VALUE_BITS-1:0]       cand_ff;
   logic [tdpg_pkg::VALUE_BITS-1:0]       prime_ff;
   logic [tdpg_pkg::SQ_BITS-1:0]          sq_ff;
   logic [tdpg_pkg::VALUE_BITS-1:0]       res_cand_ff;
   logic                                  res_prime_ff;
   logic [tdpg_pkg::RSP_DATA_BITS-1:0]    rsp_tdata_ff;
   logic                                  rsp_tvalid_ff;

   logic                                  accept;
   logic                                  done_now;
   logic                                  last_try;
   logic                                  check_prime;
   logic                                  commit;
   logic                                  found_prime;
   logic                                  table_room;
   logic                                  div_start;
   logic                                  out_free;
   logic                                  ram_wr_en;
   logic [tdpg_pkg::VALUE_BITS-1:0]       ram_rd_data;
   logic [tdpg_pkg::VALUE_BITS-1:0]       prime_in;
   logic [tdpg_pkg::SQ_BITS-1:0]          sq_in;
   tdpg_pkg::mod_result_type              mod_res;

   always_comb begin
      accept      = req_tvalid && (state_ff == S_IDLE);
      done_now    = next_cand_ff > {1'b0, limit_ff};
      last_try    = (idx_ff + tdpg_pkg::COUNT_BITS'(1)) >= count_ff;
      check_prime = (prime_ff < tdpg_pkg::FIRST_PRIME) ||
                    (sq_ff > tdpg_pkg::SQ_BITS'(cand_ff));
      commit      = ((state_ff == S_CHECK) && check_prime) ||
                    ((state_ff == S_DIVIDE) && mod_res.done &&
                     (mod_res.zero || last_try));
      found_prime = (state_ff == S_CHECK) ? 1'b1 : !mod_res.zero;
      table_room  = count_ff < tdpg_pkg::COUNT_BITS'(tdpg_pkg::TABLE_DEPTH);
      ram_wr_en   = commit && found_prime && table_room;
      div_start   = (state_ff == S_CHECK) && !check_prime;
      out_free    = !rsp_tvalid_ff || rsp_tready;
      // entry 0 is the fixed prime 2, never read from the RAM
      prime_in    = (idx_ff == '0) ? tdpg_pkg::FIRST_PRIME : ram_rd_data;
      sq_in       = tdpg_pkg::SQ_BITS'(prime_ff) * tdpg_pkg::SQ_BITS'(prime_ff);
   end

   tdpg_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[tdpg_pkg::ADDR_BITS-1:0]),
      .wr_data (cand_ff),
      .rd_addr (idx_ff[tdpg_pkg::ADDR_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   tdpg_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cand_ff),
      .divisor  (prime_ff),
      .result   (mod_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         limit_ff      <= tdpg_pkg::LIMIT_RESET;
         next_cand_ff  <= tdpg_pkg::FIRST_CAND;
         count_ff      <= tdpg_pkg::COUNT_BITS'(1);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         // in S_FINISH the output register is reloaded instead
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_FINISH)) begin
            rsp_tvalid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  res_cand_ff  <= '0;
                  res_prime_ff <= 1'b0;
                  idx_ff       <= '0;
                  cand_ff      <= next_cand_ff[tdpg_pkg::VALUE_BITS-1:0];
                  if (req_tdata[0]) begin
                     next_cand_ff <= tdpg_pkg::FIRST_CAND;
                     count_ff     <= tdpg_pkg::COUNT_BITS'(1);
                     state_ff     <= S_FINISH;
                  end else if (done_now) begin
                     state_ff <= S_FINISH;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               prime_ff <= prime_in;
               state_ff <= S_SQUARE;
            end
            S_SQUARE: begin
               sq_ff    <= sq_in;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               state_ff <= check_prime ? S_FINISH : S_DIVIDE;
            end
            S_DIVIDE: begin
               if (mod_res.done && !commit) begin
                  idx_ff   <= idx_ff + tdpg_pkg::COUNT_BITS'(1);
                  state_ff <= S_READ;
               end else if (commit) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_tdata_ff  <= {
                     {(tdpg_pkg::RSP_DATA_BITS - tdpg_pkg::RSP_FIELD_BITS){1'b0}},
                     done_now, count_ff, res_prime_ff, res_cand_ff};
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // end of a test: report, store a new prime, step the candidate
         if (commit) begin
            res_cand_ff  <= cand_ff;
            res_prime_ff <= found_prime;
            next_cand_ff <= next_cand_ff + tdpg_pkg::NEXT_BITS'(2);
            if (found_prime && table_room) begin
               count_ff <= count_ff + tdpg_pkg::COUNT_BITS'(1);
            end
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule
